[src/string_hash_index_assert.svh]
// assertion macros shared by the rtl files
`ifndef STRING_HASH_INDEX_ASSERT_SVH
`define STRING_HASH_INDEX_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define SHI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SHI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/shi_pkg.sv]
package shi_pkg;

	localparam int DIV_W  = 32;
	localparam int REM_W  = 16;
	localparam int MOD_W  = 17;
	localparam int CNT_W  = 5;
	localparam int POLY_W = 24;
	localparam int CHAR_W = 7;
	localparam int LEN_W  = 8;
	localparam int MODE_W = 3;

	localparam logic [REM_W-1:0]  ADLER_MOD  = 16'd65521;
	localparam logic [LEN_W-1:0]  POLY_PRIME = 8'd89;
	localparam logic [LEN_W-1:0]  BASE_TWO   = 8'd2;
	localparam int                MIX_SHIFT  = 12;
	localparam int                HIGH_SHIFT = 16;
	localparam logic [MOD_W-1:0]  FULL_MOD   = 17'h10000;
	localparam logic [REM_W-1:0]  SIZE_RESET = 16'd1024;

	localparam logic [CNT_W-1:0] POLY_STEPS = CNT_W'(POLY_W - 1);
	localparam logic [CNT_W-1:0] WORD_STEPS = CNT_W'(DIV_W - 1);

	localparam logic [MODE_W-1:0] MODE_BASE89 = 3'd0;
	localparam logic [MODE_W-1:0] MODE_BASE2  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BASELEN = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SUM    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ADLER  = 3'd4;

	localparam logic REG_HASH_MODE  = 1'b0;
	localparam logic REG_TABLE_SIZE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM_B,
		ST_MIX,
		ST_REDUCE,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic             load;
		logic [DIV_W-1:0] dividend;
		logic [CNT_W-1:0] steps;
	} mod_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mod_sts_t;

	typedef struct packed {
		logic clear;
		logic upd_a;
		logic upd_b;
	} adl_ctl_t;

endpackage

[src/shi_mod_unit.sv]
`include "string_hash_index_assert.svh"

module shi_mod_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  shi_pkg::mod_ctl_t          ctl,
	input  logic [shi_pkg::MOD_W-1:0]  modulus,
	output logic [shi_pkg::REM_W-1:0]  remainder,
	output shi_pkg::mod_sts_t          sts
);
	import shi_pkg::*;

	logic [DIV_W-1:0] div_q;
	logic [REM_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [MOD_W-1:0] shifted;
	logic [MOD_W-1:0] diff;
	logic [REM_W-1:0] rem_d;

	// one restoring step per cycle while busy
	always_comb begin
		shifted = {rem_q, div_q[DIV_W-1]};
		diff    = shifted - modulus;
		rem_d   = (shifted >= modulus) ? diff[REM_W-1:0] : shifted[REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (ctl.load) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.steps;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			div_q <= ctl.dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			div_q <= {div_q[DIV_W-2:0], 1'b0};
			rem_q <= rem_d;
		end
	end

	assign remainder = rem_q;
	assign sts.busy  = busy_q;
	assign sts.done  = done_q;

	`SHI_ASSERT_NOW(a_rem_below_mod, done_q, {1'b0, rem_q} < modulus, "remainder not reduced")
	`SHI_ASSERT_NOW(a_done_not_busy, done_q && !ctl.load, !busy_q, "done while busy")
	`SHI_ASSERT_NEXT(a_count_down, busy_q && !ctl.load && (cnt_q != '0),
		busy_q && (cnt_q == $past(cnt_q) - 5'd1), "step counter slipped")

endmodule

[src/shi_adler.sv]
module shi_adler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  shi_pkg::adl_ctl_t           ctl,
	input  logic [shi_pkg::CHAR_W-1:0]  character,
	output logic [shi_pkg::DIV_W-1:0]   mixed
);
	import shi_pkg::*;

	logic [REM_W-1:0] a_q;
	logic [REM_W-1:0] b_q;
	logic [REM_W:0]   a_sum;
	logic [REM_W:0]   b_sum;
	logic [REM_W-1:0] a_d;
	logic [REM_W-1:0] b_d;
	logic [DIV_W-1:0] word;

	always_comb begin
		a_sum = {1'b0, a_q} + (REM_W+1)'(character);
		a_d   = (a_sum >= {1'b0, ADLER_MOD}) ? 16'(a_sum - {1'b0, ADLER_MOD}) : a_sum[REM_W-1:0];
		b_sum = {1'b0, b_q} + {1'b0, a_q};
		b_d   = (b_sum >= {1'b0, ADLER_MOD}) ? 16'(b_sum - {1'b0, ADLER_MOD}) : b_sum[REM_W-1:0];
		word  = (DIV_W'(b_q) << HIGH_SHIFT) | DIV_W'(a_q);
		mixed = word ^ (word >> MIX_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 16'd1;
			b_q <= '0;
		end else if (ctl.clear) begin
			a_q <= 16'd1;
			b_q <= '0;
		end else begin
			if (ctl.upd_a) begin
				a_q <= a_d;
			end
			if (ctl.upd_b) begin
				b_q <= b_d;
			end
		end
	end

endmodule

[src/string_hash_index.sv]
// string_hash_index: key hash to bucket index, one character per item
// a character is accepted only in idle; key_stall holds the next one until the reducer is through with it
// a final character's result passes through sum_b, the Adler mix in mode 4, the reducer and the done state
// an empty key goes straight to the done state, and its result is valid once the output is free
// the shared restoring reducer takes 24 steps per character, 32 for the final one in mode 4
// async reset: mode 0, table size 1024, no key in progress, no result pending
`include "string_hash_index_assert.svh"

module string_hash_index (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        key_valid,
	output logic                        key_stall,
	input  logic [shi_pkg::CHAR_W-1:0]  character,
	input  logic [shi_pkg::LEN_W-1:0]   key_length,
	input  logic                        last_char,
	input  logic                        empty_key,
	output logic                        bucket_valid,
	input  logic                        bucket_stall,
	output logic [shi_pkg::REM_W-1:0]   bucket_index
);
	import shi_pkg::*;

	seq_state_t state_q;
	seq_state_t state_d;

	logic [MODE_W-1:0] hash_mode_q;
	logic [REM_W-1:0]  table_size_q;
	logic [MODE_W-1:0] mode_q;
	logic              last_q;
	logic [REM_W-1:0]  rh_q;
	logic [REM_W-1:0]  res_q;
	logic              bucket_valid_q;
	logic [REM_W-1:0]  bucket_index_q;

	logic [MODE_W-1:0] mode_eff;
	logic [MOD_W-1:0]  modulus;
	logic [LEN_W-1:0]  base;
	logic [POLY_W-1:0] poly;
	logic [REM_W-1:0]  empty_res;
	logic              cfg_wr;
	logic              accept;

	logic              rh_load;
	logic              key_clear;
	logic              res_empty;
	logic              res_mod;
	logic              out_load;

	mod_ctl_t          mod_ctl;
	mod_sts_t          mod_sts;
	adl_ctl_t          adl_ctl;
	logic [REM_W-1:0]  remainder;
	logic [DIV_W-1:0]  adl_mix;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign accept = key_valid && !key_stall;

	always_comb begin
		case (paddr[2])
			REG_HASH_MODE:  prdata = 32'(hash_mode_q);
			REG_TABLE_SIZE: prdata = 32'(table_size_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_mode_q  <= MODE_BASE89;
			table_size_q <= SIZE_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_HASH_MODE:  hash_mode_q  <= pwdata[MODE_W-1:0];
				REG_TABLE_SIZE: table_size_q <= pwdata[REM_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		mode_eff = (hash_mode_q > MODE_ADLER) ? MODE_BASE89 : hash_mode_q;
		modulus  = (table_size_q == '0) ? FULL_MOD : {1'b0, table_size_q};
		case (mode_eff)
			MODE_BASE2:   base = BASE_TWO;
			MODE_BASELEN: base = key_length;
			default:      base = POLY_PRIME;
		endcase
		if (mode_eff == MODE_SUM) begin
			poly = POLY_W'(rh_q) + POLY_W'(character);
		end else begin
			poly = POLY_W'(base) * POLY_W'(rh_q) + POLY_W'(character);
		end
		// hash of the empty key is 1 mod m in mode 4
		empty_res = ((mode_eff == MODE_ADLER) && (table_size_q != 16'd1)) ? 16'd1 : '0;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (key_valid) begin
					state_d = empty_key ? ST_DONE : ST_SUM_B;
				end
			end
			ST_SUM_B: begin
				state_d = (last_q && (mode_q == MODE_ADLER)) ? ST_MIX : ST_REDUCE;
			end
			ST_MIX: begin
				state_d = ST_REDUCE;
			end
			ST_REDUCE: begin
				if (mod_sts.done) begin
					state_d = last_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_DONE: begin
				if (!bucket_valid_q || !bucket_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		key_stall        = 1'b1;
		mod_ctl.load     = 1'b0;
		mod_ctl.dividend = {poly, 8'd0};
		mod_ctl.steps    = POLY_STEPS;
		adl_ctl.clear    = 1'b0;
		adl_ctl.upd_a    = 1'b0;
		adl_ctl.upd_b    = 1'b0;
		rh_load          = 1'b0;
		key_clear        = 1'b0;
		res_empty        = 1'b0;
		res_mod          = 1'b0;
		out_load         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				key_stall = 1'b0;
				if (key_valid) begin
					if (empty_key) begin
						key_clear = 1'b1;
						res_empty = 1'b1;
					end else begin
						adl_ctl.upd_a = 1'b1;
						mod_ctl.load  = !(last_char && (mode_eff == MODE_ADLER));
					end
				end
			end
			ST_SUM_B: begin
				adl_ctl.upd_b = 1'b1;
			end
			ST_MIX: begin
				mod_ctl.load     = 1'b1;
				mod_ctl.dividend = adl_mix;
				mod_ctl.steps    = WORD_STEPS;
			end
			ST_REDUCE: begin
				if (mod_sts.done) begin
					if (last_q) begin
						res_mod   = 1'b1;
						key_clear = 1'b1;
					end else begin
						rh_load = 1'b1;
					end
				end
			end
			ST_DONE: begin
				out_load = !bucket_valid_q || !bucket_stall;
			end
			default: ;
		endcase
		adl_ctl.clear = key_clear;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rh_q           <= '0;
			bucket_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (key_clear) begin
				rh_q <= '0;
			end else if (rh_load) begin
				rh_q <= remainder;
			end
			if (out_load) begin
				bucket_valid_q <= 1'b1;
			end else if (!bucket_stall) begin
				bucket_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_eff;
			last_q <= last_char;
		end
		if (res_empty) begin
			res_q <= empty_res;
		end else if (res_mod) begin
			res_q <= remainder;
		end
		if (out_load) begin
			bucket_index_q <= res_q;
		end
	end

	assign bucket_valid = bucket_valid_q;
	assign bucket_index = bucket_index_q;

	shi_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mod_ctl),
		.modulus   (modulus),
		.remainder (remainder),
		.sts       (mod_sts)
	);

	shi_adler u_adler (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (adl_ctl),
		.character (character),
		.mixed     (adl_mix)
	);

	`SHI_ASSERT_NOW(a_done_in_reduce, mod_sts.done, state_q == ST_REDUCE, "reducer finished out of step")
	`SHI_ASSERT_NOW(a_reduce_has_work, state_q == ST_REDUCE, mod_sts.busy || mod_sts.done,
		"waiting on an idle reducer")
	`SHI_ASSERT_NOW(a_done_state_clear, state_q == ST_DONE, rh_q == '0, "key state not cleared")

endmodule
